/* design/urt_pkg.sv */
// shared types and constants of the ultrasonic ranging timer
package urt_pkg;

  // field widths
  localparam int unsigned TrigW   = 10;
  localparam int unsigned CountW  = 20;
  localparam int unsigned SelW    = 2;
  localparam int unsigned EchoW   = 2;
  localparam int unsigned CfgIdxW = 2;

  // operation codes
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_TRIGGER = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HOLDOFF = 2'd2;

  // configuration reset values
  localparam logic [TrigW-1:0]  TRIGGER_RST = 10'd10;
  localparam logic [CountW-1:0] TIMEOUT_RST = 20'd62500;
  localparam logic [CountW-1:0] HOLDOFF_RST = 20'd600;

  localparam logic [CountW-1:0] COUNT_MAX = {CountW{1'b1}};

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BUSY    = 2'd1,
    ST_TIMEOUT = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  // configuration as seen by the measurement engine
  typedef struct packed {
    logic [TrigW-1:0]  trigger_ticks;
    logic [CountW-1:0] timeout_ticks;
    logic [CountW-1:0] holdoff_ticks;
  } urt_cfg_t;

  // one result transaction
  typedef struct packed {
    logic [EchoW-1:0]  trigger_levels;
    logic              done_res;
    status_e           status;
    logic [SelW-1:0]   result_sensor;
    logic [CountW-1:0] elapsed_ticks;
  } urt_result_t;

endpackage

/* design/urt_core.sv */
// measurement engine: phase state, counters and per-item result logic
module urt_core import urt_pkg::*; #(
  parameter int unsigned NUM_SENSORS = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_en_i,
  input  logic              operation_i,
  input  logic [SelW-1:0]   sensor_select_i,
  input  logic [EchoW-1:0]  echo_levels_i,
  input  urt_cfg_t          cfg_i,
  output urt_result_t       result_o
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_WAIT = 2'd2
  } phase_e;

  localparam logic [SelW:0] SensorLimit = (SelW+1)'(NUM_SENSORS);

  phase_e            phase_q, phase_d;
  logic              active_q, active_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] hold_q, hold_d;
  logic [EchoW-1:0]  prev_echo_q, prev_echo_d;

  logic              is_idle;
  logic [CountW-1:0] count_inc;
  logic              fall;

  assign is_idle   = !(phase_q == PH_TRIG || phase_q == PH_WAIT);
  assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;
  assign fall      = prev_echo_q[active_q] & ~echo_levels_i[active_q];

  // next state and result for one transaction
  always_comb begin
    phase_d     = phase_q;
    active_d    = active_q;
    count_d     = count_q;
    hold_d      = hold_q;
    prev_echo_d = prev_echo_q;
    result_o    = '0;
    result_o.status = ST_OK;

    if (operation_i == OP_REQUEST) begin
      if (!is_idle || hold_q != '0) begin
        result_o.done_res      = 1'b1;
        result_o.status        = ST_BUSY;
        result_o.result_sensor = sensor_select_i;
      end else if ({1'b0, sensor_select_i} >= SensorLimit) begin
        result_o.done_res      = 1'b1;
        result_o.status        = ST_INVALID;
        result_o.result_sensor = sensor_select_i;
      end else begin
        phase_d  = PH_TRIG;
        active_d = sensor_select_i[0];
        count_d  = '0;
      end
    end else begin
      if (hold_q != '0) begin
        hold_d = hold_q - 1'b1;
      end
      case (phase_q)
        PH_TRIG: begin
          if (count_inc >= CountW'(cfg_i.trigger_ticks)) begin
            phase_d = PH_WAIT;
            count_d = '0;
          end else begin
            count_d = count_inc;
          end
        end
        PH_WAIT: begin
          count_d = count_inc;
          if (fall) begin
            result_o.done_res      = 1'b1;
            result_o.status        = ST_OK;
            result_o.result_sensor = {1'b0, active_q};
            result_o.elapsed_ticks = count_inc;
            hold_d  = cfg_i.holdoff_ticks;
            phase_d = PH_IDLE;
            count_d = '0;
          end else if (count_inc >= cfg_i.timeout_ticks) begin
            result_o.done_res      = 1'b1;
            result_o.status        = ST_TIMEOUT;
            result_o.result_sensor = {1'b0, active_q};
            phase_d = PH_IDLE;
            count_d = '0;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
      prev_echo_d = echo_levels_i;
    end

    // trigger drive after this transaction
    if (phase_d == PH_TRIG) begin
      result_o.trigger_levels[active_d] = 1'b1;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      active_q    <= 1'b0;
      count_q     <= '0;
      hold_q      <= '0;
      prev_echo_q <= '0;
    end else if (step_en_i) begin
      phase_q     <= phase_d;
      active_q    <= active_d;
      count_q     <= count_d;
      hold_q      <= hold_d;
      prev_echo_q <= prev_echo_d;
    end
  end

endmodule

/* design/ultrasonic_ranging_timer_unit.sv */
// top level of the ultrasonic ranging timer
// Two-sensor ultrasonic ranging timer. Each input transaction is either one
// time tick or a measurement request; each yields exactly one result
// transaction carrying the trigger drive levels, a done flag, status, sensor
// and the elapsed ticks from trigger end to echo falling edge. A transaction
// accepted into the input register is processed by the measurement engine
// and lands in the result register once the output is free; the result is
// then offered from there. A new item is accepted every cycle unless the
// input stalls, which happens only while both registers hold data and the
// output is stalled; the measurement engine updates its state once per item.
// Configuration is written through a plain write port and must only change
// while the block is idle.
module ultrasonic_ranging_timer_unit import urt_pkg::*; #(
  parameter int unsigned NUM_SENSORS = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CountW-1:0]  cfg_data_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic [SelW-1:0]    sensor_select_i,
  input  logic [EchoW-1:0]   echo_levels_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [EchoW-1:0]   trigger_levels_o,
  output logic               done_res_o,
  output logic [1:0]         status_o,
  output logic [SelW-1:0]    result_sensor_o,
  output logic [CountW-1:0]  elapsed_ticks_o
);

  urt_cfg_t          cfg_q;
  logic              in_valid_q;
  logic              op_q;
  logic [SelW-1:0]   sel_q;
  logic [EchoW-1:0]  echo_q;
  logic              out_valid_q;
  urt_result_t       res_q, res_d;
  logic              in_accept;
  logic              advance;

  // handshake: input register feeds result register
  assign advance    = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_ticks <= TRIGGER_RST;
      cfg_q.timeout_ticks <= TIMEOUT_RST;
      cfg_q.holdoff_ticks <= HOLDOFF_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TRIGGER: cfg_q.trigger_ticks <= cfg_data_i[TrigW-1:0];
        CFG_TIMEOUT: cfg_q.timeout_ticks <= cfg_data_i;
        CFG_HOLDOFF: cfg_q.holdoff_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= operation_i;
      sel_q  <= sensor_select_i;
      echo_q <= echo_levels_i;
    end
  end

  urt_core #(
    .NUM_SENSORS(NUM_SENSORS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_en_i      (advance),
    .operation_i    (op_q),
    .sensor_select_i(sel_q),
    .echo_levels_i  (echo_q),
    .cfg_i          (cfg_q),
    .result_o       (res_d)
  );

  // result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign trigger_levels_o = res_q.trigger_levels;
  assign done_res_o       = res_q.done_res;
  assign status_o         = res_q.status;
  assign result_sensor_o  = res_q.result_sensor;
  assign elapsed_ticks_o  = res_q.elapsed_ticks;

endmodule
